/* rtl/core/dpnf_pkg.sv */
package dpnf_pkg;

  // Field widths on the ports
  localparam int PORT_W  = 16;
  localparam int COMP_N  = 4;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 3;

  // Register indexes of the configuration port
  localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_HALF_X          = 3'd2;
  localparam logic [CIDX_W-1:0] REG_HALF_Y          = 3'd3;
  localparam logic [CIDX_W-1:0] REG_COMPONENTS_USED = 3'd4;

  // Operation codes of an input beat
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Frame geometry limit on rows
  localparam int MAX_HEIGHT = 4096;

  // Controls shared by all component cells
  typedef struct packed {
    logic clear;
    logic acc;
    logic load;
    logic step;
  } cell_ctrl_t;

endpackage

/* rtl/core/dpnf_in_if.sv */
interface dpnf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [dpnf_pkg::PORT_W-1:0]  sample_c0;
  logic [dpnf_pkg::PORT_W-1:0]  sample_c1;
  logic [dpnf_pkg::PORT_W-1:0]  sample_c2;
  logic [dpnf_pkg::PORT_W-1:0]  sample_c3;
  logic                         unlabeled;
  logic                         dead;

  modport source (output valid, operation, sample_c0, sample_c1, sample_c2, sample_c3,
                  unlabeled, dead, input ready);
  modport sink (input valid, operation, sample_c0, sample_c1, sample_c2, sample_c3,
                unlabeled, dead, output ready);
endinterface

/* rtl/core/dpnf_out_if.sv */
interface dpnf_out_if;
  logic                         valid;
  logic                         ready;
  logic [dpnf_pkg::PORT_W-1:0]  out_c0;
  logic [dpnf_pkg::PORT_W-1:0]  out_c1;
  logic [dpnf_pkg::PORT_W-1:0]  out_c2;
  logic [dpnf_pkg::PORT_W-1:0]  out_c3;
  logic                         filled;
  logic                         last_of_frame;

  modport source (output valid, out_c0, out_c1, out_c2, out_c3, filled, last_of_frame,
                  input ready);
  modport sink (input valid, out_c0, out_c1, out_c2, out_c3, filled, last_of_frame,
                output ready);
endinterface

/* rtl/core/dpnf_ram.sv */
module dpnf_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 18432
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* rtl/core/dpnf_cell.sv */
module dpnf_cell #(
  parameter int S_BITS = 16,
  parameter int C_BITS = 7
) (
  input  logic                   clk,
  input  dpnf_pkg::cell_ctrl_t   ctl,
  input  logic [S_BITS-1:0]      sample,
  input  logic [C_BITS-1:0]      count,
  output logic [S_BITS-1:0]      quot
);
  import dpnf_pkg::*;

  localparam int SUM_W = S_BITS + C_BITS;

  logic [SUM_W-1:0]  sum;
  logic [C_BITS-1:0] rem;
  logic [C_BITS:0]   trial;
  logic              fits;

  // Shift one dividend bit into the partial remainder
  assign trial = {rem, quot[S_BITS-1]};
  assign fits  = (trial >= {1'b0, count});

  // Accumulate live neighbors, then divide one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum <= '0;
    end else if (ctl.acc) begin
      sum <= sum + SUM_W'(sample);
    end
    if (ctl.load) begin
      rem  <= sum[SUM_W-1:S_BITS];
      quot <= sum[S_BITS-1:0];
    end else if (ctl.step) begin
      rem  <= fits ? C_BITS'(trial - {1'b0, count}) : C_BITS'(trial);
      quot <= {quot[S_BITS-2:0], fits};
    end
  end
endmodule

/* rtl/core/dead_pixel_neighbor_fill.sv */
// Channel  | Modport            | Beat carries
// in_item  | dpnf_in_if.sink    | operation, sample_c0..c3, unlabeled, dead
// out_item | dpnf_out_if.source | out_c0..c3, filled, last_of_frame
// cfg      | write only         | cfg_wr_en, cfg_index, cfg_data
//
// One item at a time. A pixel that emits nothing stops after the position steps; an
// emitted pixel that is not a hole also reads its center; a hole then walks the
// (2*half_x+1)*(2*half_y+1) window, one line store read per cycle, and runs the
// bit-serial divide; a hole with no live neighbor skips the divide. Beats taken
// while a frame tail is pending skip the position steps. rst is synchronous; the
// line store is not cleared. A result waits in the output register while the next
// item is taken; the last step holds while an earlier result is still waiting there.
module dead_pixel_neighbor_fill #(
  parameter int MAX_WIDTH   = 2048,
  parameter int MAX_HALF_X  = 4,
  parameter int MAX_HALF_Y  = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [dpnf_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [dpnf_pkg::CFG_W-1:0]    cfg_data,
  dpnf_in_if.sink                       in_item,
  dpnf_out_if.source                    out_item
);
  import dpnf_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int RING   = 2 * MAX_HALF_Y + 1;
  localparam int RW     = $clog2(RING);
  localparam int AW     = RW + COL_W;
  localparam int DEPTH  = RING << COL_W;
  localparam int MEM_W  = COMP_N * SAMPLE_BITS + 2;
  localparam int HXW    = $clog2(MAX_HALF_X + 1);
  localparam int HYW    = $clog2(MAX_HALF_Y + 1);
  localparam int NEIGH  = (2 * MAX_HALF_X + 1) * (2 * MAX_HALF_Y + 1) - 1;
  localparam int CNT_W  = $clog2(NEIGH + 1);
  localparam int BIT_W  = $clog2(SAMPLE_BITS);
  localparam int XW     = COL_W + 2;
  localparam int YW     = 14;
  localparam int RYW    = RW + 2;
  localparam int LW     = COL_W + 14;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_LAG    = 12'b000000000010,
    S_NPOS   = 12'b000000000100,
    S_OPOS   = 12'b000000001000,
    S_DECIDE = 12'b000000010000,
    S_CREAD  = 12'b000000100000,
    S_CWAIT  = 12'b000001000000,
    S_WALK   = 12'b000010000000,
    S_WTAIL  = 12'b000100000000,
    S_DSTART = 12'b001000000000,
    S_DIV    = 12'b010000000000,
    S_FIN    = 12'b100000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [12:0] width_r;
  logic [12:0] height_r;
  logic [2:0]  hx_r, hy_r, nc_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= 13'd2048;
      height_r <= 13'd64;
      hx_r     <= 3'd1;
      hy_r     <= 3'd1;
      nc_r     <= 3'd4;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:     width_r  <= {1'b0, cfg_data[11:0]};
        REG_IMAGE_HEIGHT:    height_r <= cfg_data;
        REG_HALF_X:          hx_r     <= cfg_data[2:0];
        REG_HALF_Y:          hy_r     <= cfg_data[2:0];
        REG_COMPONENTS_USED: nc_r     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [COL_W:0] eff_w;
  logic [12:0]    eff_h;
  logic [HXW-1:0] eff_hx;
  logic [HYW-1:0] eff_hy;

  always_comb begin
    if (width_r == 13'd0) eff_w = (COL_W + 1)'(1);
    else if (32'(width_r) > MAX_WIDTH) eff_w = (COL_W + 1)'(MAX_WIDTH);
    else eff_w = (COL_W + 1)'(width_r);
    if (height_r == 13'd0) eff_h = 13'd1;
    else if (32'(height_r) > MAX_HEIGHT) eff_h = 13'(MAX_HEIGHT);
    else eff_h = height_r;
    eff_hx = (32'(hx_r) > MAX_HALF_X) ? HXW'(MAX_HALF_X) : HXW'(hx_r);
    eff_hy = (32'(hy_r) > MAX_HALF_Y) ? HYW'(MAX_HALF_Y) : HYW'(hy_r);
  end

  // Position counters
  logic [11:0]      in_row, out_row, n_row;
  logic [COL_W-1:0] in_col, out_col, n_col;
  logic [RW-1:0]    in_ring, out_ring;
  logic             tail_pending, pix_done, drain_mode;
  logic             in_fire, out_free, col_end, row_end;
  logic             in_col_end, in_row_end;

  assign in_item.ready = (state == S_IDLE);
  assign in_fire  = in_item.valid && in_item.ready;
  assign out_free = !out_item.valid || out_item.ready;

  assign in_col_end = ({1'b0, in_col} + (COL_W + 1)'(1) >= eff_w);
  assign in_row_end = (13'(in_row) + 13'd1 >= eff_h);
  assign col_end    = ({1'b0, out_col} + (COL_W + 1)'(1) >= eff_w);
  assign row_end    = (13'(out_row) + 13'd1 >= eff_h);

  // Line store
  logic             mem_we;
  logic [AW-1:0]    rd_addr;
  logic [MEM_W-1:0] rd_data, wr_data, center;

  assign mem_we  = in_fire && (in_item.operation == OP_PIXEL) && !tail_pending;
  assign wr_data = {in_item.dead, in_item.unlabeled,
                    in_item.sample_c3[SAMPLE_BITS-1:0], in_item.sample_c2[SAMPLE_BITS-1:0],
                    in_item.sample_c1[SAMPLE_BITS-1:0], in_item.sample_c0[SAMPLE_BITS-1:0]};

  dpnf_ram #(.WIDTH(MEM_W), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr ({in_ring, in_col}),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared multiplier for the linear positions
  logic [11:0]   mul_a;
  logic [LW-1:0] product;
  logic [LW-1:0] lag_r, n_r, ol_r;

  always_comb begin
    unique case (state)
      S_LAG:   mul_a = 12'(eff_hy);
      S_NPOS:  mul_a = n_row;
      default: mul_a = out_row;
    endcase
  end
  assign product = LW'(mul_a) * LW'(eff_w);

  // Window walk position
  logic signed [HXW:0]  dx;
  logic signed [HYW:0]  dy;
  logic signed [XW-1:0] x_pos;
  logic signed [YW-1:0] y_pos;
  logic signed [RYW-1:0] y_ring_raw;
  logic [RW-1:0]        y_ring;
  logic                 pos_ok, pend_ok, walk_last;
  logic [CNT_W-1:0]     count_r;
  logic [BIT_W-1:0]     bit_cnt;
  logic                 filled_r;

  always_comb begin
    x_pos = $signed({2'b00, out_col}) + XW'(dx);
    y_pos = $signed({2'b00, out_row}) + YW'(dy);
    y_ring_raw = $signed({2'b00, out_ring}) + RYW'(dy);
    if (y_ring_raw < 0) y_ring = RW'(y_ring_raw + RYW'(RING));
    else if (y_ring_raw >= RYW'(RING)) y_ring = RW'(y_ring_raw - RYW'(RING));
    else y_ring = RW'(y_ring_raw);
    pos_ok = (x_pos >= 0) && (x_pos < $signed({1'b0, eff_w})) &&
             (y_pos >= 0) && (y_pos < $signed({1'b0, eff_h})) &&
             !((dx == 0) && (dy == 0));
    walk_last = (dx == $signed({1'b0, eff_hx})) && (dy == $signed({1'b0, eff_hy}));
  end

  // Read address: center first, then the walk
  always_comb begin
    if (state == S_WALK) rd_addr = {y_ring, x_pos[COL_W-1:0]};
    else rd_addr = {out_ring, out_col};
  end

  // Component cells
  cell_ctrl_t cctl;
  logic [SAMPLE_BITS-1:0] quot [COMP_N];

  assign cctl.clear = (state == S_CWAIT);
  assign cctl.acc   = pend_ok && !rd_data[MEM_W-1];
  assign cctl.load  = (state == S_DSTART);
  assign cctl.step  = (state == S_DIV);

  for (genvar k = 0; k < COMP_N; k++) begin : g_cell
    dpnf_cell #(.S_BITS(SAMPLE_BITS), .C_BITS(CNT_W)) u_cell (
      .clk    (clk),
      .ctl    (cctl),
      .sample (rd_data[k*SAMPLE_BITS +: SAMPLE_BITS]),
      .count  (count_r),
      .quot   (quot[k])
    );
  end

  // Output register
  logic [PORT_W-1:0] out_c [COMP_N];
  logic              out_filled, out_last, out_valid;
  logic [PORT_W-1:0] fin_c [COMP_N];

  always_comb begin
    for (int k = 0; k < COMP_N; k++) begin
      if (32'(nc_r) <= k) fin_c[k] = '0;
      else if (filled_r) fin_c[k] = PORT_W'(quot[k]);
      else fin_c[k] = PORT_W'(center[k*SAMPLE_BITS +: SAMPLE_BITS]);
    end
  end

  assign out_item.valid         = out_valid;
  assign out_item.out_c0        = out_c[0];
  assign out_item.out_c1        = out_c[1];
  assign out_item.out_c2        = out_c[2];
  assign out_item.out_c3        = out_c[3];
  assign out_item.filled        = out_filled;
  assign out_item.last_of_frame = out_last;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_row       <= '0;
      in_col       <= '0;
      in_ring      <= '0;
      out_row      <= '0;
      out_col      <= '0;
      out_ring     <= '0;
      tail_pending <= 1'b0;
      pend_ok      <= 1'b0;
      out_valid    <= 1'b0;
      count_r      <= '0;
    end else begin
      pend_ok <= (state == S_WALK) && pos_ok;
      if (cctl.acc) count_r <= count_r + CNT_W'(1);
      if (out_item.valid && out_item.ready && (state != S_FIN)) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            drain_mode <= (in_item.operation == OP_DRAIN) || tail_pending;
            if (tail_pending) begin
              state <= S_CREAD;
            end else if (in_item.operation == OP_PIXEL) begin
              n_row <= in_row;
              n_col <= in_col;
              pix_done <= in_col_end && in_row_end;
              if (in_col_end) begin
                in_col <= '0;
                if (in_row_end) begin
                  in_row  <= '0;
                  in_ring <= '0;
                end else begin
                  in_row  <= in_row + 12'd1;
                  in_ring <= (32'(in_ring) == RING - 1) ? '0 : in_ring + RW'(1);
                end
              end else begin
                in_col <= in_col + COL_W'(1);
              end
              state <= S_LAG;
            end
          end
        end
        S_LAG: begin
          lag_r <= product + LW'(eff_hx);
          state <= S_NPOS;
        end
        S_NPOS: begin
          n_r   <= product + LW'(n_col);
          state <= S_OPOS;
        end
        S_OPOS: begin
          ol_r  <= product + LW'(out_col);
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (((LW + 1)'(ol_r) + (LW + 1)'(lag_r)) <= (LW + 1)'(n_r)) begin
            state <= S_CREAD;
          end else begin
            tail_pending <= pix_done;
            state <= S_IDLE;
          end
        end
        S_CREAD: state <= S_CWAIT;
        S_CWAIT: begin
          center   <= rd_data;
          filled_r <= 1'b0;
          count_r  <= '0;
          dx <= -$signed({1'b0, eff_hx});
          dy <= -$signed({1'b0, eff_hy});
          if (rd_data[MEM_W-1] && rd_data[MEM_W-2]) state <= S_WALK;
          else state <= S_FIN;
        end
        S_WALK: begin
          if (walk_last) begin
            state <= S_WTAIL;
          end else if (dx == $signed({1'b0, eff_hx})) begin
            dx <= -$signed({1'b0, eff_hx});
            dy <= dy + (HYW+1)'(1);
          end else begin
            dx <= dx + (HXW+1)'(1);
          end
        end
        S_WTAIL: state <= S_DSTART;
        S_DSTART: begin
          bit_cnt <= '0;
          if (count_r == '0) state <= S_FIN;
          else state <= S_DIV;
        end
        S_DIV: begin
          bit_cnt <= bit_cnt + BIT_W'(1);
          if (32'(bit_cnt) == SAMPLE_BITS - 1) begin
            filled_r <= 1'b1;
            state    <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            for (int k = 0; k < COMP_N; k++) out_c[k] <= fin_c[k];
            out_filled <= filled_r;
            out_last   <= col_end && row_end;
            if (col_end) begin
              out_col <= '0;
              if (row_end) begin
                out_row  <= '0;
                out_ring <= '0;
              end else begin
                out_row  <= out_row + 12'd1;
                out_ring <= (32'(out_ring) == RING - 1) ? '0 : out_ring + RW'(1);
              end
            end else begin
              out_col <= out_col + COL_W'(1);
            end
            if (drain_mode) begin
              if (col_end && row_end) tail_pending <= 1'b0;
            end else begin
              tail_pending <= pix_done && !(col_end && row_end);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(count_r) <= NEIGH))
    else $error("live neighbor count exceeds window");
  a_pend_walk: assert property (@(posedge clk) disable iff (rst)
    pend_ok |-> ($past(state) == S_WALK))
    else $error("accumulate outside the window walk");
`endif
endmodule
